// ===== sv/rdcf_pkg.sv =====
package rdcf_pkg;

   // Gains and fade factors are Q1.15
   localparam int unsigned FRAC_BITS = 15;
   localparam logic [15:0] Q15_ONE   = 16'h8000;

   // Register field widths
   localparam int unsigned DELAY_BITS = 17;
   localparam int unsigned FB_BITS    = 15;
   localparam int unsigned MIX_BITS   = 16;
   localparam int unsigned XF_BITS    = 15;
   localparam int unsigned CSR_BITS   = 17;
   localparam int unsigned CSR_IDX_BITS = 2;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_DELAY    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FEEDBACK = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIX      = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_XFADE    = 2'd3;

   // Register reset values
   localparam logic [DELAY_BITS-1:0] DELAY_RST    = 17'd44100;
   localparam logic [FB_BITS-1:0]    FEEDBACK_RST = 15'd9830;
   localparam logic [MIX_BITS-1:0]   MIX_RST      = 16'd16384;
   localparam logic [XF_BITS-1:0]    XFADE_RST    = 15'd3277;

   // Divider step counter
   localparam int unsigned DIV_CNT_BITS = 4;

   typedef enum logic [11:0] {
      ST_CLEAR   = 12'b0000_0000_0001,
      ST_IDLE    = 12'b0000_0000_0010,
      ST_WRITE   = 12'b0000_0000_0100,
      ST_RDISSUE = 12'b0000_0000_1000,
      ST_FADE    = 12'b0000_0001_0000,
      ST_DIV     = 12'b0000_0010_0000,
      ST_FMUL    = 12'b0000_0100_0000,
      ST_MIX1    = 12'b0000_1000_0000,
      ST_MIX2    = 12'b0001_0000_0000,
      ST_OUT     = 12'b0010_0000_0000,
      ST_SW_RD   = 12'b0100_0000_0000,
      ST_SW_WR   = 12'b1000_0000_0000
   } state_type;

endpackage

// ===== sv/rdcf_div.sv =====
module rdcf_div #(
   parameter int unsigned W = 17
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [W-1:0]                num,
   input  logic [W-1:0]                den,
   output logic                        done,
   output logic [rdcf_pkg::FRAC_BITS-1:0] quo
);
   import rdcf_pkg::*;

   // Restoring divide of (num << 15) by den, num below den: one bit a cycle
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [W-1:0]            rem_ff, rem_in;
   logic [FRAC_BITS-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [W:0]              trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      trial   = {rem_ff, 1'b0};
      if (start) begin
         busy_in = 1'b1;
         rem_in  = num;
         quo_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den}) begin
            rem_in = W'(trial - {1'b0, den});
            quo_in = {quo_ff[FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[FRAC_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(FRAC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

   // done follows the last step of a running divide
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running divide");

   // a running divide never exceeds its step count
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff < DIV_CNT_BITS'(FRAC_BITS))
      else $error("divider step count overrun");

   // a quotient is never offered while still busy
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");

endmodule

// ===== sv/reverse_delay_crossfade_unit.sv =====
// Reverse delay with edge crossfades and a dry/wet mix.
// req_ beats carry one signed input sample; each yields exactly one rsp_ beat
// with the mixed, saturated sample. csr_ writes set delay length, feedback,
// wet share and crossfade fraction; write them only while the block is idle.
// Samples live in one single-port-read, single-port-write store with a
// registered read. During playback a beat runs from the accept through the
// WRITE, RDISSUE, FADE, MIX1, MIX2 and OUT states, and OUT loads the result;
// while recording the read and fade steps are skipped. Inside a fade zone a
// bit-serial divider works out the fade factor in DIV, ahead of FMUL. When
// playback passes entry 0, a feedback sweep rescales entries 0..delay-1 with
// one read and one write step per entry before the next beat is taken.
// After reset the store is cleared, one entry a cycle; req_tready stays low
// meanwhile, csr_ writes are still taken.
// The result sits in an output register: a stalled receiver does not stop
// the next beat from being accepted and worked on; only the final load into
// the output register waits until the previous result has been taken.
module reverse_delay_crossfade_unit #(
   parameter int unsigned STORE_DEPTH = 131072,
   parameter int unsigned SAMPLE_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   // slave side: tdata = audio_in, zero padded to whole bytes
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   // master side: tdata = audio_out, zero padded to whole bytes
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,
   // configuration write port
   input  logic                                 csr_we,
   input  logic [rdcf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [rdcf_pkg::CSR_BITS-1:0]        csr_wdata
);
   import rdcf_pkg::*;

   localparam int unsigned ADDR_BITS = $clog2(STORE_DEPTH);
   localparam int unsigned TDATA_BITS = ((SAMPLE_BITS+7)/8)*8;
   localparam int unsigned MIX_PBITS = SAMPLE_BITS + 17;
   localparam int unsigned ACC_BITS = SAMPLE_BITS + 18;
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(STORE_DEPTH - 1);
   localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // ---------------------------------------------------------------- config
   logic [DELAY_BITS-1:0] delay_ff;
   logic [FB_BITS-1:0]    fb_ff;
   logic [MIX_BITS-1:0]   mix_ff;
   logic [XF_BITS-1:0]    xf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RST;
         fb_ff    <= FEEDBACK_RST;
         mix_ff   <= MIX_RST;
         xf_ff    <= XFADE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DELAY:    delay_ff <= csr_wdata[DELAY_BITS-1:0];
            CSR_FEEDBACK: fb_ff    <= csr_wdata[FB_BITS-1:0];
            CSR_MIX:      mix_ff   <= csr_wdata[MIX_BITS-1:0];
            CSR_XFADE:    xf_ff    <= csr_wdata[XF_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Effective length: zero acts as one, too long acts as STORE_DEPTH-1
   logic [ADDR_BITS-1:0] dlen;
   logic [ADDR_BITS-1:0] dlast;
   always_comb begin
      if (delay_ff == '0) begin
         dlen = ADDR_BITS'(1);
      end else if (32'(delay_ff) >= 32'(STORE_DEPTH)) begin
         dlen = LAST_ADDR;
      end else begin
         dlen = ADDR_BITS'(delay_ff);
      end
      dlast = dlen - 1'b1;
   end

   // Crossfade length, registered; first read in the fade step after an accept
   logic [ADDR_BITS-1:0]         cf_ff;
   logic [XF_BITS+ADDR_BITS-1:0] cf_prod;
   assign cf_prod = (XF_BITS+ADDR_BITS)'(xf_ff) * (XF_BITS+ADDR_BITS)'(dlen);
   always_ff @(posedge clock) begin
      cf_ff <= cf_prod[XF_BITS +: ADDR_BITS];
   end

   // Wet and dry shares, wet clamped to one
   logic [MIX_BITS-1:0] wet_g;
   logic [MIX_BITS-1:0] dry_g;
   assign wet_g = (mix_ff > Q15_ONE) ? Q15_ONE : mix_ff;
   assign dry_g = Q15_ONE - wet_g;

   // ---------------------------------------------------------------- store
   logic [SAMPLE_BITS-1:0] store_mem [STORE_DEPTH];
   logic                   mem_we;
   logic [ADDR_BITS-1:0]   mem_waddr;
   logic [SAMPLE_BITS-1:0] mem_wdata;
   logic [ADDR_BITS-1:0]   mem_raddr;
   logic [SAMPLE_BITS-1:0] mem_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= store_mem[mem_raddr];
   end

   // ---------------------------------------------------------------- control
   state_type                     state_ff, state_in;
   logic [ADDR_BITS-1:0]          w_ff, w_in;
   logic [ADDR_BITS-1:0]          r_ff, r_in;
   logic                          rec_ff, rec_in;
   logic                          wrap_ff, wrap_in;
   logic [ADDR_BITS-1:0]          sweep_ff, sweep_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [SAMPLE_BITS-1:0] s_ff, s_in;
   logic signed [SAMPLE_BITS-1:0] ws_ff, ws_in;
   logic signed [MIX_PBITS-1:0]   p_ff, p_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;

   logic                          div_start;
   logic [ADDR_BITS-1:0]          div_num;
   logic                          div_done;
   logic [FRAC_BITS-1:0]          div_quo;

   logic [ADDR_BITS-1:0]                 de;
   logic signed [SAMPLE_BITS+16:0]       fade_prod;
   logic signed [SAMPLE_BITS+16:0]       fb_prod;
   logic signed [MIX_PBITS-1:0]          wet_prod;
   logic signed [ACC_BITS-FRAC_BITS-1:0] acc_q;
   logic signed [SAMPLE_BITS-1:0]        sat_val;
   logic                                 rsp_free;

   rdcf_div #(.W(ADDR_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (cf_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      w_in         = w_ff;
      r_in         = r_ff;
      rec_in       = rec_ff;
      wrap_in      = wrap_ff;
      sweep_in     = sweep_ff;
      x_in         = x_ff;
      s_in         = s_ff;
      ws_in        = ws_ff;
      p_in         = p_ff;
      acc_in       = acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      mem_we    = 1'b0;
      mem_waddr = w_ff;
      mem_wdata = x_ff;
      mem_raddr = r_ff;
      div_start = 1'b0;

      // distance to the far end; past the end counts as zero
      de = (r_ff <= dlast) ? (dlast - r_ff) : '0;

      fade_prod = $signed(s_ff) * $signed({2'b00, div_quo});
      fb_prod   = $signed(mem_rd_ff) * $signed({2'b00, fb_ff});
      wet_prod  = $signed(ws_ff) * $signed({1'b0, wet_g});
      acc_q     = acc_ff[ACC_BITS-1:FRAC_BITS];
      if (acc_q > (ACC_BITS-FRAC_BITS)'(SAT_HI)) begin
         sat_val = SAT_HI;
      end else if (acc_q < (ACC_BITS-FRAC_BITS)'(SAT_LO)) begin
         sat_val = SAT_LO;
      end else begin
         sat_val = acc_q[SAMPLE_BITS-1:0];
      end

      case (state_ff)
         ST_CLEAR: begin
            // zero the store one entry a cycle
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in     = req_tdata[SAMPLE_BITS-1:0];
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // store the new sample, then advance the write pointer
            mem_we    = 1'b1;
            mem_waddr = w_ff;
            mem_wdata = x_ff;
            w_in      = (w_ff == LAST_ADDR) ? '0 : (w_ff + 1'b1);
            ws_in     = '0;
            wrap_in   = 1'b0;
            if (rec_ff && (w_ff >= dlast)) begin
               rec_in   = 1'b0;
               r_in     = w_ff;
               state_in = ST_RDISSUE;
            end else if (!rec_ff) begin
               state_in = ST_RDISSUE;
            end else begin
               state_in = ST_MIX1;
            end
         end
         ST_RDISSUE: begin
            mem_raddr = r_ff;
            state_in  = ST_FADE;
         end
         ST_FADE: begin
            // pick the fade zone, then step the read pointer back
            s_in = mem_rd_ff;
            if ((cf_ff != '0) && (r_ff < cf_ff)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else if ((cf_ff != '0) && (de < cf_ff)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               ws_in    = mem_rd_ff;
               state_in = ST_MIX1;
            end
            if (r_ff == '0) begin
               wrap_in = 1'b1;
               r_in    = dlast;
            end else begin
               r_in = r_ff - 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FMUL;
            end
         end
         ST_FMUL: begin
            ws_in    = fade_prod[FRAC_BITS +: SAMPLE_BITS];
            state_in = ST_MIX1;
         end
         ST_MIX1: begin
            p_in     = $signed(x_ff) * $signed({1'b0, dry_g});
            state_in = ST_MIX2;
         end
         ST_MIX2: begin
            acc_in   = ACC_BITS'(p_ff) + ACC_BITS'(wet_prod);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat_val;
               sweep_in     = '0;
               state_in     = wrap_ff ? ST_SW_RD : ST_IDLE;
            end
         end
         ST_SW_RD: begin
            mem_raddr = sweep_ff;
            state_in  = ST_SW_WR;
         end
         ST_SW_WR: begin
            // scale one entry by the feedback gain
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = fb_prod[FRAC_BITS +: SAMPLE_BITS];
            if (sweep_ff == dlast) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
               state_in = ST_SW_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // the divider numerator is the distance of the chosen zone
      div_num = ((cf_ff != '0) && (r_ff < cf_ff)) ? r_ff : de;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         w_ff         <= '0;
         r_ff         <= '0;
         rec_ff       <= 1'b1;
         wrap_ff      <= 1'b0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         w_ff         <= w_in;
         r_ff         <= r_in;
         rec_ff       <= rec_in;
         wrap_ff      <= wrap_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      s_ff        <= s_in;
      ws_ff       <= ws_in;
      p_ff        <= p_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_BITS'(rsp_data_ff[SAMPLE_BITS-1:0]);

   // ---------------------------------------------------------------- checks
   // write pointer steps by one, wrapping at the store end
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |=>
         (w_ff == (($past(w_ff) == LAST_ADDR) ? '0 : ($past(w_ff) + 1'b1))))
      else $error("write pointer did not advance by one");

   // no feedback sweep while still recording
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SW_RD) || (state_ff == ST_SW_WR)) |-> !rec_ff)
      else $error("feedback sweep during recording");

   // a quotient only arrives while waiting for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider result outside of the divide state");

   // a result loads only into a free output register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_OUT))
      else $error("result left while the output register was full");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import rdcf_pkg::*;

   localparam int unsigned DEPTH = 131072;
   localparam int unsigned SBITS = 24;
   localparam int unsigned TBITS = ((SBITS + 7) / 8) * 8;
   localparam longint      SMAX  = (longint'(1) <<< (SBITS - 1)) - 1;
   localparam longint      SMIN  = -SMAX - 1;

   typedef logic signed [SBITS-1:0] sample_t;

   // Scoreboard: keeps its own copy of the segment store, pointers and
   // registers, predicts the mixed sample for every accepted input beat and
   // compares returned beats in order.
   class reverse_mix_board;
      bit signed [SBITS-1:0] segment [DEPTH];
      int unsigned           wr_ptr;
      int unsigned           rd_ptr;
      bit                    capturing;
      bit                    swept_last;
      int unsigned           seg_len;
      int unsigned           fb_gain;
      int unsigned           wet_gain;
      int unsigned           fade_frac;
      sample_t               mix_due [$];
      int unsigned           fails;

      function new();
         wr_ptr     = 0;
         rd_ptr     = 0;
         capturing  = 1'b1;
         swept_last = 1'b0;
         fails      = 0;
         seg_len    = 32'(DELAY_RST);
         fb_gain    = 32'(FEEDBACK_RST);
         wet_gain   = 32'(MIX_RST);
         fade_frac  = 32'(XFADE_RST);
      endfunction

      // Segment length as the block uses it: zero acts as one, clamp below depth
      function int unsigned span();
         if (seg_len == 0)
            return 1;
         if (seg_len >= DEPTH)
            return DEPTH - 1;
         return seg_len;
      endfunction

      function void set_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_BITS-1:0] val);
         case (idx)
            CSR_DELAY:    seg_len   = 32'(val[DELAY_BITS-1:0]);
            CSR_FEEDBACK: fb_gain   = 32'(val[FB_BITS-1:0]);
            CSR_MIX:      wet_gain  = 32'(val[MIX_BITS-1:0]);
            CSR_XFADE:    fade_frac = 32'(val[XF_BITS-1:0]);
            default: ;
         endcase
      endfunction

      function void take_sample(sample_t x);
         int unsigned d;
         int unsigned cf;
         int unsigned ds;
         int unsigned de;
         int unsigned wet;
         int unsigned j;
         longint      s;
         longint      fq;
         longint      faded;
         longint      acc;
         d  = span();
         cf = int'((longint'(fade_frac) * longint'(d)) >>> FRAC_BITS);
         segment[wr_ptr] = x;
         // recording stops once the write pointer reaches the segment end
         if (capturing && wr_ptr >= d - 1) begin
            capturing = 1'b0;
            rd_ptr    = wr_ptr;
         end
         faded      = 0;
         swept_last = 1'b0;
         if (!capturing) begin
            s  = longint'(segment[rd_ptr]);
            ds = rd_ptr;
            // past the segment end the end distance counts as zero
            de = (rd_ptr <= d - 1) ? d - 1 - rd_ptr : 0;
            fq = longint'(1) <<< FRAC_BITS;
            if (cf != 0 && ds < cf)
               fq = (longint'(ds) <<< FRAC_BITS) / longint'(cf);
            else if (cf != 0 && de < cf)
               fq = (longint'(de) <<< FRAC_BITS) / longint'(cf);
            faded = (s * fq) >>> FRAC_BITS;
            if (rd_ptr == 0) begin
               // wrap: restart at the segment end and scale the whole segment
               rd_ptr = d - 1;
               for (j = 0; j < d; j++)
                  segment[j] = sample_t'((longint'(segment[j]) * longint'(fb_gain))
                                         >>> FRAC_BITS);
               swept_last = 1'b1;
            end else begin
               rd_ptr--;
            end
         end
         wr_ptr = (wr_ptr + 1) % DEPTH;
         wet = (wet_gain > Q15_ONE) ? Q15_ONE : wet_gain;
         acc = (longint'(x) * longint'(Q15_ONE - wet) + faded * longint'(wet)) >>> FRAC_BITS;
         if (acc > SMAX)
            acc = SMAX;
         else if (acc < SMIN)
            acc = SMIN;
         mix_due.push_back(sample_t'(acc));
      endfunction

      function void check_mix(sample_t y);
         sample_t want;
         if (mix_due.size() == 0) begin
            fails++;
            if (fails <= 40)
               $display("%0t audio_out mismatch: expected none, actual %0d", $time, y);
            return;
         end
         want = mix_due.pop_front();
         if (y !== want) begin
            fails++;
            if (fails <= 40)
               $display("%0t audio_out mismatch: expected %0d, actual %0d", $time, want, y);
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [TBITS-1:0]        req_tdata;    // [23:0] audio_in
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [TBITS-1:0]        rsp_tdata;    // [23:0] audio_out
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_BITS-1:0]     csr_wdata;

   // idle odds in percent for the sender and the receiver
   int unsigned      send_idle_pct;
   int unsigned      recv_stall_pct;
   reverse_mix_board board;

   reverse_delay_crossfade_unit #(
      .STORE_DEPTH(DEPTH),
      .SAMPLE_BITS(SBITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: pick ready at the falling edge, take the beat at the rising edge
   always begin
      @(negedge clock);
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      @(posedge clock);
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_mix(rsp_tdata[SBITS-1:0]);
   end

   // Write one register; the enable stays high so back-to-back writes need no drop
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input int unsigned val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_BITS-1:0];
      @(posedge clock);
      board.set_reg(idx, val[CSR_BITS-1:0]);
   endtask

   task automatic program_regs(input int unsigned len, input int unsigned fb,
                               input int unsigned mix, input int unsigned xf);
      write_reg(CSR_DELAY, len);
      write_reg(CSR_FEEDBACK, fb);
      write_reg(CSR_MIX, mix);
      write_reg(CSR_XFADE, xf);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Offer one beat, inserting idle cycles at random, and hold it until taken
   task automatic send_sample(input sample_t x);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TBITS'(x);
      do
         @(posedge clock);
      while (!req_tready);
      board.take_sample(x);
   endtask

   // Drop valid, wait for every predicted beat, then let a feedback sweep finish
   task automatic drain_and_settle();
      int unsigned hold;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.mix_due.size() != 0)
         @(posedge clock);
      hold = board.swept_last ? 2 * board.span() + 64 : 64;
      repeat (hold) @(posedge clock);
   endtask

   initial begin
      sample_t     corner_vals [9];
      sample_t     x;
      int unsigned len;
      int unsigned fb;
      int unsigned mix;
      int unsigned xf;
      int unsigned count;
      int unsigned p;
      int unsigned n;

      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_DELAY;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      board          = new();
      corner_vals    = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF, 24'sh000001,
                         24'sh555555, 24'shAAAAAA, 24'sh400000, 24'shC00000};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Recording only: the segment is not yet full, so only the dry share comes out.
      // Registers may be written during the clearing pass.
      program_regs(40, 32767, 16384, 16384);
      foreach (corner_vals[i])
         send_sample(corner_vals[i]);
      repeat (7)
         send_sample(sample_t'($urandom));
      drain_and_settle();

      // Shrink the segment below the write pointer: playback starts past the
      // segment end, full crossfade fraction, wet share above one.
      program_regs(4, 0, 65535, 32767);
      foreach (corner_vals[i])
         send_sample(corner_vals[i]);
      drain_and_settle();

      // Random samples, settings fixed for p < 4; the idle pattern rotates with p
      for (p = 0; p < 12; p++) begin
         case (p)
            0: begin len = 0;      fb = 9830;  mix = 32768; xf = 0;     end
            1: begin len = 64;     fb = 32767; mix = 0;     xf = 32767; end
            2: begin len = 300;    fb = 29491; mix = 32768; xf = 3277;  end
            3: begin len = 131071; fb = 16384; mix = 24576; xf = 16384; end
            default: begin
               len = $urandom_range(48);
               fb  = $urandom_range(32767);
               mix = ($urandom_range(3) == 0) ? 32768 : $urandom_range(65535);
               xf  = $urandom_range(32767);
            end
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         // The longest segment must not wrap here: a full-length sweep is slow and
         // would leave the read pointer far beyond any later, shorter segment.
         count = 160;
         if (p == 3 && board.rd_ptr < count)
            count = board.rd_ptr;
         program_regs(len, fb, mix, xf);
         for (n = 0; n < count; n++) begin
            case ($urandom_range(15))
               0: x = 24'sh7FFFFF;
               1: x = 24'sh800000;
               2: x = 24'sh000000;
               default: x = sample_t'($urandom);
            endcase
            send_sample(x);
         end
         drain_and_settle();
      end

      if (board.fails == 0 && board.mix_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #100_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
